### rtl/core/sct_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and the reciprocal-factorial coefficients for the
// series sine and cosine block. No dependencies.
package sct_pkg;

  localparam int TERMS_DEF = 10;

  localparam int ANGLE_W = 31;
  localparam int OUT_W   = 32;
  localparam int MAG_W   = 30;
  localparam int X2_W    = 32;
  localparam int ACC_W   = 36;
  localparam int HALF_W  = 16;
  localparam int PART_W  = ACC_W + HALF_W + 1;
  localparam int PROD_W  = ACC_W + X2_W + 2;
  localparam int FRAC    = 28;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX     = 31'sd843314857;
  localparam logic signed [ANGLE_W-1:0] NEG_ANGLE_MAX = -31'sd843314857;
  localparam logic [OUT_W-1:0]          ONE_Q30       = 32'd1073741824;

  function automatic logic [OUT_W-1:0] inv_fact(input int n);
    logic [OUT_W-1:0] c;
    case (n)
      0:       c = 32'd1073741824;
      1:       c = 32'd1073741824;
      2:       c = 32'd536870912;
      3:       c = 32'd178956971;
      4:       c = 32'd44739243;
      5:       c = 32'd8947849;
      6:       c = 32'd1491308;
      7:       c = 32'd213044;
      8:       c = 32'd26631;
      9:       c = 32'd2959;
      10:      c = 32'd296;
      11:      c = 32'd27;
      12:      c = 32'd2;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/sine_cosine_taylor_series.sv
`timescale 1ns / 1ps
// Stages in order: input register, squaring, rounding of x squared, the Horner
// steps, the final sine product and its rounding, and the output register.
// Throughput: one angle per cycle while the skid entry is empty; each Horner step of the series is a
// multiply stage followed by a round-and-subtract stage, both lanes in step.
// A two-entry output stage absorbs a stalled result without losing a beat.
// Reset clears every valid bit at once; no clearing pass is needed.
module sine_cosine_taylor_series #(
  parameter int TERMS = sct_pkg::TERMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [30:0] angle, [31] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // [31:0] sine_value, [63:32] cosine_value
);

  localparam int STEPS  = TERMS - 1;
  localparam int ACC_W  = sct_pkg::ACC_W;
  localparam int PROD_W = sct_pkg::PROD_W;
  localparam int PART_W = sct_pkg::PART_W;
  localparam int HALF_W = sct_pkg::HALF_W;
  localparam int MAG_W  = sct_pkg::MAG_W;
  localparam int X2_W   = sct_pkg::X2_W;
  localparam int OUT_W  = sct_pkg::OUT_W;
  localparam int FRAC   = sct_pkg::FRAC;
  localparam int SQ_W   = 2 * MAG_W + 1;

  localparam logic signed [ACC_W-1:0] ACC_C_INIT = ACC_W'(sct_pkg::inv_fact(2 * TERMS - 2));
  localparam logic signed [ACC_W-1:0] ACC_S_INIT = ACC_W'(sct_pkg::inv_fact(2 * TERMS - 1));
  localparam logic signed [ACC_W-1:0] ONE_ACC    = ACC_W'(sct_pkg::ONE_Q30);
  localparam logic signed [ACC_W-1:0] NEG_ONE    = -ONE_ACC;
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (FRAC - 1);
  localparam logic [SQ_W-1:0]          SQ_HALF   = SQ_W'(1) << (FRAC - 1);

  function automatic logic signed [PROD_W-1:0] join_parts(
    input logic signed [PART_W-1:0] hi,
    input logic signed [PART_W-1:0] lo
  );
    return (PROD_W'(hi) <<< HALF_W) + PROD_W'(lo);
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd_shift(
    input logic signed [PROD_W-1:0] p,
    input logic                     neg
  );
    logic signed [PROD_W-1:0] s;
    s = p + PROD_HALF - PROD_W'(neg);
    return s[FRAC+ACC_W-1:FRAC];
  endfunction

  function automatic logic [OUT_W-1:0] sat_one(input logic signed [ACC_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v > ONE_ACC) begin
      r = ONE_ACC[OUT_W-1:0];
    end else if (v < NEG_ONE) begin
      r = NEG_ONE[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  logic en;
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic out_load, out_from_skid, skid_load;
  logic [2*OUT_W-1:0] out_data_q, skid_data_q, tail_data;

  assign en = !skid_valid_q;
  assign s_axis_tready_o = en;

  // Input stage: clamp to +-pi and split into magnitude and sign.
  logic signed [sct_pkg::ANGLE_W-1:0] ang_in, ang_clamp, ang_abs;
  logic              s0_v_q;
  logic [MAG_W-1:0]  s0_mag_q;
  logic              s0_neg_q;

  assign ang_in = s_axis_tdata_i[sct_pkg::ANGLE_W-1:0];

  always_comb begin
    if (ang_in > sct_pkg::ANGLE_MAX) begin
      ang_clamp = sct_pkg::ANGLE_MAX;
    end else if (ang_in < sct_pkg::NEG_ANGLE_MAX) begin
      ang_clamp = sct_pkg::NEG_ANGLE_MAX;
    end else begin
      ang_clamp = ang_in;
    end
    ang_abs = ang_clamp[sct_pkg::ANGLE_W-1] ? -ang_clamp : ang_clamp;
  end

  // Squaring and rounding of x squared.
  logic              s1_v_q, s2_v_q;
  logic [2*MAG_W-1:0] s1_sq_q;
  logic [SQ_W-1:0]   sq_rnd;
  logic [MAG_W-1:0]  s1_mag_q, s2_mag_q;
  logic              s1_neg_q, s2_neg_q;
  logic [X2_W-1:0]   s2_x2_q;

  assign sq_rnd = {1'b0, s1_sq_q} + SQ_HALF;

  // Horner step registers, one entry per step.
  logic                      a_v_q   [STEPS];
  logic signed [PART_W-1:0]  a_cl_q  [STEPS];
  logic signed [PART_W-1:0]  a_ch_q  [STEPS];
  logic signed [PART_W-1:0]  a_sl_q  [STEPS];
  logic signed [PART_W-1:0]  a_sh_q  [STEPS];
  logic                      a_nc_q  [STEPS];
  logic                      a_ns_q  [STEPS];
  logic [X2_W-1:0]           a_x2_q  [STEPS];
  logic [MAG_W-1:0]          a_mag_q [STEPS];
  logic                      a_neg_q [STEPS];
  logic                      b_v_q   [STEPS];
  logic signed [ACC_W-1:0]   b_c_q   [STEPS];
  logic signed [ACC_W-1:0]   b_s_q   [STEPS];
  logic [X2_W-1:0]           b_x2_q  [STEPS];
  logic [MAG_W-1:0]          b_mag_q [STEPS];
  logic                      b_neg_q [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int K = STEPS - 1 - j;
    localparam logic signed [ACC_W-1:0] COEF_C = ACC_W'(sct_pkg::inv_fact(2 * K));
    localparam logic signed [ACC_W-1:0] COEF_S = ACC_W'(sct_pkg::inv_fact(2 * K + 1));

    logic                    in_v;
    logic [X2_W-1:0]         in_x2;
    logic signed [ACC_W-1:0] in_c, in_s;
    logic [MAG_W-1:0]        in_mag;
    logic                    in_neg;

    if (j == 0) begin : g_first
      assign in_v   = s2_v_q;
      assign in_x2  = s2_x2_q;
      assign in_c   = ACC_C_INIT;
      assign in_s   = ACC_S_INIT;
      assign in_mag = s2_mag_q;
      assign in_neg = s2_neg_q;
    end else begin : g_next
      assign in_v   = b_v_q[j-1];
      assign in_x2  = b_x2_q[j-1];
      assign in_c   = b_c_q[j-1];
      assign in_s   = b_s_q[j-1];
      assign in_mag = b_mag_q[j-1];
      assign in_neg = b_neg_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q[j] <= 1'b0;
        b_v_q[j] <= 1'b0;
      end else if (en) begin
        a_v_q[j] <= in_v;
        b_v_q[j] <= a_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        a_cl_q[j]  <= PART_W'(in_c) * PART_W'($signed({1'b0, in_x2[HALF_W-1:0]}));
        a_ch_q[j]  <= PART_W'(in_c) * PART_W'($signed({1'b0, in_x2[X2_W-1:HALF_W]}));
        a_sl_q[j]  <= PART_W'(in_s) * PART_W'($signed({1'b0, in_x2[HALF_W-1:0]}));
        a_sh_q[j]  <= PART_W'(in_s) * PART_W'($signed({1'b0, in_x2[X2_W-1:HALF_W]}));
        a_nc_q[j]  <= in_c[ACC_W-1];
        a_ns_q[j]  <= in_s[ACC_W-1];
        a_x2_q[j]  <= in_x2;
        a_mag_q[j] <= in_mag;
        a_neg_q[j] <= in_neg;
        b_c_q[j]   <= COEF_C - rnd_shift(join_parts(a_ch_q[j], a_cl_q[j]), a_nc_q[j]);
        b_s_q[j]   <= COEF_S - rnd_shift(join_parts(a_sh_q[j], a_sl_q[j]), a_ns_q[j]);
        b_x2_q[j]  <= a_x2_q[j];
        b_mag_q[j] <= a_mag_q[j];
        b_neg_q[j] <= a_neg_q[j];
      end
    end
  end

  // Final sine product: magnitude of the angle times the sine accumulator.
  logic                     f_v_q, g_v_q;
  logic signed [PART_W-1:0] f_pl_q, f_ph_q;
  logic                     f_ns_q, f_neg_q, g_neg_q;
  logic signed [ACC_W-1:0]  f_c_q, g_c_q, g_s_q, sin_pre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      f_v_q  <= 1'b0;
      g_v_q  <= 1'b0;
    end else if (en) begin
      s0_v_q <= s_axis_tvalid_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      f_v_q  <= b_v_q[STEPS-1];
      g_v_q  <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_mag_q <= ang_abs[MAG_W-1:0];
      s0_neg_q <= ang_clamp[sct_pkg::ANGLE_W-1];
      s1_sq_q  <= {{MAG_W{1'b0}}, s0_mag_q} * {{MAG_W{1'b0}}, s0_mag_q};
      s1_mag_q <= s0_mag_q;
      s1_neg_q <= s0_neg_q;
      s2_x2_q  <= sq_rnd[FRAC+X2_W-1:FRAC];
      s2_mag_q <= s1_mag_q;
      s2_neg_q <= s1_neg_q;
      f_pl_q   <= PART_W'(b_s_q[STEPS-1]) *
                  PART_W'($signed({1'b0, b_mag_q[STEPS-1][HALF_W-1:0]}));
      f_ph_q   <= PART_W'(b_s_q[STEPS-1]) *
                  PART_W'($signed({1'b0, b_mag_q[STEPS-1][MAG_W-1:HALF_W]}));
      f_ns_q   <= b_s_q[STEPS-1][ACC_W-1];
      f_neg_q  <= b_neg_q[STEPS-1];
      f_c_q    <= b_c_q[STEPS-1];
      g_s_q    <= rnd_shift(join_parts(f_ph_q, f_pl_q), f_ns_q);
      g_c_q    <= f_c_q;
      g_neg_q  <= f_neg_q;
    end
  end

  assign sin_pre   = g_neg_q ? -g_s_q : g_s_q;
  assign tail_data = {sat_one(g_c_q), sat_one(sin_pre)};

  // Output register with a skid entry behind it.
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    out_load      = 1'b0;
    out_from_skid = 1'b0;
    skid_load     = 1'b0;
    if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_valid_d   = 1'b1;
        out_load      = 1'b1;
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end else begin
        out_valid_d = g_v_q;
        out_load    = g_v_q;
      end
    end else if (g_v_q && en) begin
      skid_valid_d = 1'b1;
      skid_load    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_load) begin
      skid_data_q <= tail_data;
    end
    if (out_load) begin
      out_data_q <= out_from_skid ? skid_data_q : tail_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### rtl/core/sct_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the series sine and cosine block, bound to the top
// level. Depends on sct_pkg and sine_cosine_taylor_series.
module sct_checker #(
  parameter int TERMS = sct_pkg::TERMS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);

  localparam int MAX_OCC = 2 * TERMS + 5;
  localparam int CNT_W   = $clog2(MAX_OCC + 2);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] occ_q, occ_d;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    occ_d = occ_q + CNT_W'(in_acc) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // A result waiting at the output is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction dropped or changed while stalled");

  // With nothing at the output, the skid entry is empty and input is taken.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output");

  // Every result follows an accepted angle.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (occ_q != '0))
    else $error("result without a matching input transaction");

  // The pipeline never holds more items than it has stages.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(MAX_OCC))
    else $error("more transactions in flight than pipeline stages");

  // Results never exceed plus or minus one.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(m_axis_tdata_o[31:0]) <= $signed(sct_pkg::ONE_Q30)) &&
      ($signed(m_axis_tdata_o[31:0]) >= -$signed(sct_pkg::ONE_Q30)) &&
      ($signed(m_axis_tdata_o[63:32]) <= $signed(sct_pkg::ONE_Q30)) &&
      ($signed(m_axis_tdata_o[63:32]) >= -$signed(sct_pkg::ONE_Q30)))
    else $error("result outside plus or minus one");

endmodule

bind sine_cosine_taylor_series sct_checker #(
  .TERMS(TERMS)
) u_sct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

### bench/tb_sine_cosine_taylor_series.sv
`timescale 1ns / 1ps
// Self-checking bench for sine_cosine_taylor_series: streams angles, predicts the
// rounded Horner series for sine and cosine and checks every result in order.
// Depends on sct_pkg and the sine_cosine_taylor_series RTL.
module tb_sine_cosine_taylor_series;

  localparam int     TERMS        = sct_pkg::TERMS_DEF;
  localparam int     RANDOM_ITEMS = 1800;
  localparam int     IDLE_LIMIT   = 4000;
  localparam int     TAIL_CYCLES  = 2 * TERMS + 3 + 16;
  localparam int     REPORT_LIMIT = 100;
  localparam longint UNIT_Q30     = 1073741824;
  localparam longint ANGLE_LIMIT  = longint'(sct_pkg::ANGLE_MAX);

  typedef struct packed {
    logic signed [31:0] cosine;
    logic signed [31:0] sine;
  } trig_pair_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  logic [30:0] angle_queue[$];
  trig_pair_t  expected_trig[$];

  int          gap_left      = 0;
  int          burst_left    = 0;
  int          idle_cycles   = 0;
  int          mismatch_count = 0;
  logic [31:0] ready_pattern = '1;
  logic [4:0]  ready_phase   = '0;

  sine_cosine_taylor_series #(
    .TERMS(TERMS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint recip_fact(int n);
    longint c;
    case (n)
      0:       c = 1073741824;
      1:       c = 1073741824;
      2:       c = 536870912;
      3:       c = 178956971;
      4:       c = 44739243;
      5:       c = 8947849;
      6:       c = 1491308;
      7:       c = 213044;
      8:       c = 26631;
      9:       c = 2959;
      10:      c = 296;
      11:      c = 27;
      12:      c = 2;
      default: c = 0;
    endcase
    return c;
  endfunction

  // Product scaled down by the fraction width, rounded half away from zero.
  function automatic longint round_product(longint a, longint b);
    logic            neg;
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = ua * ub;
    p   = (p + (64'd1 << (sct_pkg::FRAC - 1))) >> sct_pkg::FRAC;
    p   = p & 64'h3FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [31:0] clip_unit(longint v);
    if (v > UNIT_Q30) v = UNIT_Q30;
    if (v < -UNIT_Q30) v = -UNIT_Q30;
    return v[31:0];
  endfunction

  function automatic trig_pair_t series_trig(logic [30:0] raw);
    longint     a;
    longint     x2;
    longint     acc_c;
    longint     acc_s;
    trig_pair_t r;
    a = {{33{raw[30]}}, raw};
    if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
    if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
    x2    = round_product(a, a);
    acc_c = recip_fact(2 * (TERMS - 1));
    acc_s = recip_fact(2 * (TERMS - 1) + 1);
    for (int k = TERMS - 2; k >= 0; k--) begin
      acc_c = recip_fact(2 * k) - round_product(x2, acc_c);
      acc_s = recip_fact(2 * k + 1) - round_product(x2, acc_s);
    end
    r.sine   = clip_unit(round_product(a, acc_s));
    r.cosine = clip_unit(acc_c);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        expected_trig.push_back(series_trig(s_tdata[30:0]));
        void'(angle_queue.pop_front());
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (angle_queue.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, angle_queue[0]};
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (ready_phase == 5'd0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = $urandom();
        2:       ready_pattern = $urandom() | $urandom();
        default: ready_pattern = ($urandom() & $urandom()) | 32'h1;
      endcase
    end
    m_tready    <= ready_pattern[ready_phase];
    ready_phase = ready_phase + 5'd1;
  end

  always @(posedge clk_i) begin
    trig_pair_t got;
    trig_pair_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_trig.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result transaction, sine %0d cosine %0d",
                     $time, got.sine, got.cosine);
        end else begin
          want = expected_trig.pop_front();
          if (got.sine !== want.sine) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: sine_value expected %0d, actual %0d",
                       $time, want.sine, got.sine);
          end
          if (got.cosine !== want.cosine) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: cosine_value expected %0d, actual %0d",
                       $time, want.cosine, got.cosine);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int directed[18];
    int pick;
    int v;
    directed = '{0, 1, -1, 843314857, -843314857, 843314858, -843314858,
                 32'h3FFF_FFFF, -32'sh4000_0000, 421657428, -421657428,
                 210828714, 632486143, 268435456, -268435456, 16384,
                 32'h2AAA_AAAA, 32'h5555_5555};
    foreach (directed[i]) angle_queue.push_back(directed[i][30:0]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        v = int'($urandom_range(0, 2 * 843314857)) - 843314857;
      end else if (pick == 8) begin
        v = int'($urandom_range(0, 65536));
        if ($urandom_range(0, 1) == 1) v = -v;
      end else begin
        v = $urandom();
      end
      angle_queue.push_back(v[30:0]);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (angle_queue.size() != 0 || expected_trig.size() != 0 || s_tvalid)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
